### design/gain_scheduled_velocity_pid_core_macros.svh
`ifndef GAIN_SCHEDULED_VELOCITY_PID_CORE_MACROS_SVH
`define GAIN_SCHEDULED_VELOCITY_PID_CORE_MACROS_SVH

// Clocked check, off while reset is held
`define GSVP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication
`define GSVP_ASSERT_IMP(lbl, pre, post, msg) \
  `GSVP_ASSERT(lbl, (pre) |-> (post), msg)

// Next-cycle implication
`define GSVP_ASSERT_NXT(lbl, pre, post, msg) \
  `GSVP_ASSERT(lbl, (pre) |=> (post), msg)

`endif

### design/gsvp_pkg.sv
package gsvp_pkg;

  localparam int GAIN_W    = 16;
  localparam int TGT_W     = 7;
  localparam int MEAS_W    = 8;
  localparam int ERR_W     = 9;
  localparam int INT_W     = 8;
  localparam int DER_W     = 10;
  localparam int ISUM_W    = 10;
  localparam int SUM_W     = 28;
  localparam int PCT_W     = 7;
  localparam int MV_W      = 14;
  localparam int CFG_IDX_W = 3;

  localparam int GAIN_SPLIT     = 70;
  localparam int INTEGRAL_LIMIT = 100;
  localparam int DRIVE_MAX      = 100;
  localparam int MV_PER_PERCENT = 120;

  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_KP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_KI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_KD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_KP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_KI  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_KD  = 3'd5;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gain_set_t;

endpackage

### design/gain_scheduled_velocity_pid_core.sv
// Gain-scheduled velocity PID. One control tick per input transfer, one result per tick.
// A new tick is taken every cycle unless stalled; each result goes through the pipeline
// registers: error, clamped integral and derivative with gain-set selection in
// the first stage, the three gain products in the second, sum, scaling, clamp to 0..100
// percent and millivolt conversion in the output register. The integral and last-error
// state advance on each input transfer. Output back-pressure stalls the pipeline;
// in_ready drops only when all three stages are full and the output is not taken. The
// user must write gains through the cfg port only while idle; the block does not check.
`include "gain_scheduled_velocity_pid_core_macros.svh"

module gain_scheduled_velocity_pid_core #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [gsvp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gsvp_pkg::GAIN_W-1:0]        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [gsvp_pkg::TGT_W-1:0]         in_target_velocity,
  input  logic signed [gsvp_pkg::MEAS_W-1:0] in_measured_velocity,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [gsvp_pkg::PCT_W-1:0]         out_drive_percent,
  output logic [gsvp_pkg::MV_W-1:0]          out_drive_millivolts
);

  localparam int SW = gsvp_pkg::SUM_W;

  logic                                  in_xfer;
  logic                                  out_adv;
  logic                                  s2_adv;
  logic                                  s1_adv;

  logic signed [gsvp_pkg::ERR_W-1:0]     err;
  logic signed [gsvp_pkg::ISUM_W-1:0]    integ_sum;
  logic signed [gsvp_pkg::INT_W-1:0]     integ_nxt;
  logic signed [gsvp_pkg::DER_W-1:0]     deriv;
  logic                                  high_sel;
  gsvp_pkg::gain_set_t                   gain_sel;

  logic signed [gsvp_pkg::INT_W-1:0]     integ_r;
  logic signed [gsvp_pkg::ERR_W-1:0]     prev_err_r;

  logic                                  s1_v_r;
  logic signed [gsvp_pkg::ERR_W-1:0]     s1_err_r;
  logic signed [gsvp_pkg::INT_W-1:0]     s1_integ_r;
  logic signed [gsvp_pkg::DER_W-1:0]     s1_deriv_r;
  gsvp_pkg::gain_set_t                   s1_gain_r;

  logic signed [SW-1:0]                  p_nxt, i_nxt, d_nxt;
  logic                                  s2_v_r;
  logic signed [SW-1:0]                  s2_p_r, s2_i_r, s2_d_r;

  logic signed [SW-1:0]                  sum;
  logic [SW-1:0]                         quot;
  logic [gsvp_pkg::PCT_W-1:0]            drive;
  logic [gsvp_pkg::MV_W-1:0]             drive_ext;
  logic [gsvp_pkg::MV_W-1:0]             mv;

  logic                                  out_valid_r;
  logic [gsvp_pkg::PCT_W-1:0]            drive_pct_r;
  logic [gsvp_pkg::MV_W-1:0]             drive_mv_r;

  assign out_adv  = !out_valid_r || out_ready;
  assign s2_adv   = !s2_v_r || out_adv;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_ready = s1_adv;
  assign in_xfer  = in_valid && in_ready;

  assign err = $signed({2'b00, in_target_velocity})
             - $signed({in_measured_velocity[gsvp_pkg::MEAS_W-1], in_measured_velocity});
  assign integ_sum = $signed({{2{integ_r[gsvp_pkg::INT_W-1]}}, integ_r})
                   + $signed({err[gsvp_pkg::ERR_W-1], err});
  assign deriv = $signed({err[gsvp_pkg::ERR_W-1], err})
               - $signed({prev_err_r[gsvp_pkg::ERR_W-1], prev_err_r});
  assign high_sel = in_target_velocity > gsvp_pkg::TGT_W'(gsvp_pkg::GAIN_SPLIT);

  always_comb begin
    priority if (integ_sum > gsvp_pkg::INTEGRAL_LIMIT) begin
      integ_nxt = gsvp_pkg::INT_W'(gsvp_pkg::INTEGRAL_LIMIT);
    end else if (integ_sum < -gsvp_pkg::INTEGRAL_LIMIT) begin
      integ_nxt = gsvp_pkg::INT_W'(-gsvp_pkg::INTEGRAL_LIMIT);
    end else begin
      integ_nxt = integ_sum[gsvp_pkg::INT_W-1:0];
    end
  end

  gsvp_gain_regs u_gain_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .high_sel  (high_sel),
    .gain_sel  (gain_sel)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      prev_err_r <= '0;
      s1_v_r     <= 1'b0;
    end else begin
      if (in_xfer) begin
        integ_r    <= integ_nxt;
        prev_err_r <= err;
      end
      if (s1_adv) begin
        s1_v_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_err_r   <= err;
      s1_integ_r <= integ_nxt;
      s1_deriv_r <= deriv;
      s1_gain_r  <= gain_sel;
    end
  end

  assign p_nxt = $signed({{(SW-gsvp_pkg::GAIN_W){1'b0}}, s1_gain_r.kp})
               * $signed({{(SW-gsvp_pkg::ERR_W){s1_err_r[gsvp_pkg::ERR_W-1]}}, s1_err_r});
  assign i_nxt = $signed({{(SW-gsvp_pkg::GAIN_W){1'b0}}, s1_gain_r.ki})
               * $signed({{(SW-gsvp_pkg::INT_W){s1_integ_r[gsvp_pkg::INT_W-1]}}, s1_integ_r});
  assign d_nxt = $signed({{(SW-gsvp_pkg::GAIN_W){1'b0}}, s1_gain_r.kd})
               * $signed({{(SW-gsvp_pkg::DER_W){s1_deriv_r[gsvp_pkg::DER_W-1]}}, s1_deriv_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_v_r) begin
      s2_p_r <= p_nxt;
      s2_i_r <= i_nxt;
      s2_d_r <= d_nxt;
    end
  end

  assign sum  = s2_p_r + s2_i_r + s2_d_r;
  assign quot = $unsigned(sum) >> GAIN_FRAC_BITS;

  always_comb begin
    priority if (sum[SW-1]) begin
      drive = '0;
    end else if (quot > SW'(gsvp_pkg::DRIVE_MAX)) begin
      drive = gsvp_pkg::PCT_W'(gsvp_pkg::DRIVE_MAX);
    end else begin
      drive = quot[gsvp_pkg::PCT_W-1:0];
    end
  end

  assign drive_ext = {{(gsvp_pkg::MV_W-gsvp_pkg::PCT_W){1'b0}}, drive};
  assign mv        = (drive_ext << 7) - (drive_ext << 3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s2_v_r) begin
      drive_pct_r <= drive;
      drive_mv_r  <= mv;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_drive_percent    = drive_pct_r;
  assign out_drive_millivolts = drive_mv_r;

  `GSVP_ASSERT_NXT(a_integ_range, in_xfer,
    (integ_r <= gsvp_pkg::INTEGRAL_LIMIT) && (integ_r >= -gsvp_pkg::INTEGRAL_LIMIT),
    "integral out of range")
  `GSVP_ASSERT_NXT(a_prev_err, in_xfer, prev_err_r == $past(err), "last error not updated")
  `GSVP_ASSERT_IMP(a_stall_only_full, !in_ready,
    s1_v_r && s2_v_r && out_valid_r && !out_ready, "input stalled with room")
  `GSVP_ASSERT_IMP(a_drive_max, out_valid_r,
    drive_pct_r <= gsvp_pkg::PCT_W'(gsvp_pkg::DRIVE_MAX), "drive above limit")
  `GSVP_ASSERT_IMP(a_mv_match, out_valid_r,
    int'(drive_mv_r) == int'(drive_pct_r) * gsvp_pkg::MV_PER_PERCENT, "millivolts mismatch")

endmodule

### design/gsvp_gain_regs.sv
module gsvp_gain_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [gsvp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gsvp_pkg::GAIN_W-1:0]         cfg_wdata,
  input  logic                                high_sel,
  output gsvp_pkg::gain_set_t                 gain_sel
);

  gsvp_pkg::gain_set_t high_r, high_nxt;
  gsvp_pkg::gain_set_t low_r, low_nxt;

  always_comb begin
    high_nxt = high_r;
    low_nxt  = low_r;
    if (cfg_we) begin
      unique case (cfg_index)
        gsvp_pkg::CFG_HIGH_KP: high_nxt.kp = cfg_wdata;
        gsvp_pkg::CFG_HIGH_KI: high_nxt.ki = cfg_wdata;
        gsvp_pkg::CFG_HIGH_KD: high_nxt.kd = cfg_wdata;
        gsvp_pkg::CFG_LOW_KP:  low_nxt.kp  = cfg_wdata;
        gsvp_pkg::CFG_LOW_KI:  low_nxt.ki  = cfg_wdata;
        gsvp_pkg::CFG_LOW_KD:  low_nxt.kd  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r <= '0;
      low_r  <= '0;
    end else begin
      high_r <= high_nxt;
      low_r  <= low_nxt;
    end
  end

  assign gain_sel = high_sel ? high_r : low_r;

endmodule

### dv/gsvp_drive_check.sv
`timescale 1ns / 1ps

module gsvp_drive_check #(
  parameter int FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [gsvp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gsvp_pkg::GAIN_W-1:0]        cfg_wdata,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [gsvp_pkg::TGT_W-1:0]         in_target_velocity,
  input  logic signed [gsvp_pkg::MEAS_W-1:0] in_measured_velocity,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [gsvp_pkg::PCT_W-1:0]         out_drive_percent,
  input  logic [gsvp_pkg::MV_W-1:0]          out_drive_millivolts,
  output int                                 mismatches,
  output int                                 outstanding
);

  typedef struct packed {
    logic [gsvp_pkg::PCT_W-1:0] percent;
    logic [gsvp_pkg::MV_W-1:0]  millivolts;
  } drive_t;

  gsvp_pkg::gain_set_t               high_gains;
  gsvp_pkg::gain_set_t               low_gains;
  logic signed [gsvp_pkg::INT_W-1:0] error_sum;
  logic signed [gsvp_pkg::ERR_W-1:0] last_error;
  drive_t                            expected_drives[$];
  drive_t                            want;

  function automatic drive_t predict_drive(input logic [gsvp_pkg::TGT_W-1:0] tgt,
                                           input logic signed [gsvp_pkg::MEAS_W-1:0] meas);
    int                  err;
    int                  integ;
    int                  deriv;
    gsvp_pkg::gain_set_t g;
    longint              sum;
    longint              drive;
    drive_t              r;
    err = int'(tgt) - int'(meas);
    integ = int'(error_sum) + err;
    if (integ > gsvp_pkg::INTEGRAL_LIMIT) begin
      integ = gsvp_pkg::INTEGRAL_LIMIT;
    end else if (integ < -gsvp_pkg::INTEGRAL_LIMIT) begin
      integ = -gsvp_pkg::INTEGRAL_LIMIT;
    end
    error_sum = gsvp_pkg::INT_W'(integ);
    deriv = err - int'(last_error);
    last_error = gsvp_pkg::ERR_W'(err);
    g = (int'(tgt) > gsvp_pkg::GAIN_SPLIT) ? high_gains : low_gains;
    sum = longint'(g.kp) * err + longint'(g.ki) * integ + longint'(g.kd) * deriv;
    drive = sum / (longint'(1) << FRAC_BITS);
    if (drive > gsvp_pkg::DRIVE_MAX) begin
      drive = gsvp_pkg::DRIVE_MAX;
    end else if (drive < 0) begin
      drive = 0;
    end
    r.percent = gsvp_pkg::PCT_W'(drive);
    r.millivolts = gsvp_pkg::MV_W'(drive * gsvp_pkg::MV_PER_PERCENT);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] got_val);
    $display("%0t drive check: %s expected %0d got %0d", $realtime, what, exp_val, got_val);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      high_gains = '0;
      low_gains = '0;
      error_sum = '0;
      last_error = '0;
      expected_drives.delete();
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          gsvp_pkg::CFG_HIGH_KP: high_gains.kp = cfg_wdata;
          gsvp_pkg::CFG_HIGH_KI: high_gains.ki = cfg_wdata;
          gsvp_pkg::CFG_HIGH_KD: high_gains.kd = cfg_wdata;
          gsvp_pkg::CFG_LOW_KP:  low_gains.kp = cfg_wdata;
          gsvp_pkg::CFG_LOW_KI:  low_gains.ki = cfg_wdata;
          gsvp_pkg::CFG_LOW_KD:  low_gains.kd = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_drives.size() == 0) begin
          report_mismatch("unexpected result transfer, percent", 0, out_drive_percent);
        end else begin
          want = expected_drives.pop_front();
          if (out_drive_percent !== want.percent) begin
            report_mismatch("drive_percent", want.percent, out_drive_percent);
          end
          if (out_drive_millivolts !== want.millivolts) begin
            report_mismatch("drive_millivolts", want.millivolts, out_drive_millivolts);
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_drives.push_back(predict_drive(in_target_velocity, in_measured_velocity));
      end
    end
    outstanding = expected_drives.size();
  end

endmodule

### dv/gain_scheduled_velocity_pid_core_test.sv
`timescale 1ns / 1ps

module gain_scheduled_velocity_pid_core_test;

  localparam int FRAC_BITS   = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 188;

  typedef enum int {RX_OPEN, RX_MOSTLY_READY, RX_MOSTLY_STALLED, RX_PERIODIC} rx_mode_t;

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                cfg_we;
  logic [gsvp_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [gsvp_pkg::GAIN_W-1:0]         cfg_wdata;
  logic                                in_valid;
  logic                                in_ready;
  logic [gsvp_pkg::TGT_W-1:0]          in_target_velocity;
  logic signed [gsvp_pkg::MEAS_W-1:0]  in_measured_velocity;
  logic                                out_valid;
  logic                                out_ready;
  logic [gsvp_pkg::PCT_W-1:0]          out_drive_percent;
  logic [gsvp_pkg::MV_W-1:0]           out_drive_millivolts;
  int                                  mismatches;
  int                                  outstanding;
  int                                  cycle_count = 0;
  int                                  burst_left = 0;
  int                                  rx_window = 0;
  int                                  rx_tick = 0;
  rx_mode_t                            rx_mode = RX_OPEN;

  gain_scheduled_velocity_pid_core #(
    .GAIN_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_target_velocity   (in_target_velocity),
    .in_measured_velocity (in_measured_velocity),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_drive_percent    (out_drive_percent),
    .out_drive_millivolts (out_drive_millivolts)
  );

  gsvp_drive_check #(
    .FRAC_BITS(FRAC_BITS)
  ) drive_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_target_velocity   (in_target_velocity),
    .in_measured_velocity (in_measured_velocity),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_drive_percent    (out_drive_percent),
    .out_drive_millivolts (out_drive_millivolts),
    .mismatches           (mismatches),
    .outstanding          (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rx_window == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_window = $urandom_range(20, 200);
    end
    rx_window--;
    rx_tick++;
    unique case (rx_mode)
      RX_OPEN:           out_ready = 1'b1;
      RX_MOSTLY_READY:   out_ready = ($urandom_range(0, 3) != 0);
      RX_MOSTLY_STALLED: out_ready = ($urandom_range(0, 3) == 0);
      default:           out_ready = (rx_tick % 5 == 0);
    endcase
  end

  task automatic send_tick(input logic [gsvp_pkg::TGT_W-1:0] tgt,
                           input logic signed [gsvp_pkg::MEAS_W-1:0] meas);
    in_target_velocity = tgt;
    in_measured_velocity = meas;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic random_tick;
    int unsigned pick;
    int          tgt;
    int          meas;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      // track the target closely so the integral stays off its rails
      tgt = $urandom_range(0, 100);
      meas = tgt + $urandom_range(0, 20) - 10;
    end else if (pick < 85) begin
      tgt = $urandom_range(0, 100);
      meas = $urandom_range(0, 200) - 100;
    end else begin
      tgt = $urandom_range(0, 127);
      meas = $urandom_range(0, 255);
    end
    send_tick(gsvp_pkg::TGT_W'(tgt), gsvp_pkg::MEAS_W'(meas));
  endtask

  task automatic wait_idle;
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [gsvp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gsvp_pkg::GAIN_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_gains(input gsvp_pkg::gain_set_t high, input gsvp_pkg::gain_set_t low);
    wait_idle();
    cfg_write(gsvp_pkg::CFG_HIGH_KP, high.kp);
    cfg_write(gsvp_pkg::CFG_HIGH_KI, high.ki);
    cfg_write(gsvp_pkg::CFG_HIGH_KD, high.kd);
    cfg_write(gsvp_pkg::CFG_LOW_KP, low.kp);
    cfg_write(gsvp_pkg::CFG_LOW_KI, low.ki);
    cfg_write(gsvp_pkg::CFG_LOW_KD, low.kd);
    // unmapped indexes must not disturb the gains
    for (int i = gsvp_pkg::CFG_LOW_KD + 1; i < (1 << gsvp_pkg::CFG_IDX_W); i++) begin
      cfg_write(gsvp_pkg::CFG_IDX_W'(i), gsvp_pkg::GAIN_W'($urandom()));
    end
  endtask

  function automatic gsvp_pkg::gain_set_t random_gains(input int unsigned top);
    gsvp_pkg::gain_set_t g;
    g.kp = gsvp_pkg::GAIN_W'($urandom_range(0, top));
    g.ki = gsvp_pkg::GAIN_W'($urandom_range(0, top));
    g.kd = gsvp_pkg::GAIN_W'($urandom_range(0, top));
    return g;
  endfunction

  initial begin
    gsvp_pkg::gain_set_t hi_set;
    gsvp_pkg::gain_set_t lo_set;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_target_velocity = '0;
    in_measured_velocity = '0;
    out_ready = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // reset gains give zero drive
    send_tick(7'd100, -8'sd100);
    send_tick(7'd127, -8'sd128);

    hi_set = '{kp: 16'h0180, ki: 16'h0020, kd: 16'h0080};
    lo_set = '{kp: 16'h0100, ki: 16'h0010, kd: 16'h0040};
    write_gains(hi_set, lo_set);
    send_tick(7'd0, 8'sd0);
    send_tick(7'd127, -8'sd128);
    send_tick(7'd127, -8'sd128);
    send_tick(7'd127, -8'sd128);
    send_tick(7'd0, 8'sd127);
    send_tick(7'd0, 8'sd127);
    send_tick(7'd0, 8'sd127);
    send_tick(7'd70, 8'sd0);
    send_tick(7'd71, 8'sd0);
    send_tick(7'd70, 8'sd70);
    send_tick(7'd71, 8'sd71);
    send_tick(7'd100, -8'sd100);
    send_tick(7'd100, 8'sd100);
    send_tick(7'd0, -8'sd100);
    send_tick(7'd100, 8'sd0);
    send_tick(7'd50, 8'sd50);
    send_tick(7'd50, -8'sd1);
    send_tick(7'd1, -8'sd128);
    send_tick(7'd127, 8'sd127);
    send_tick(7'd85, 8'sd42);
    send_tick(7'd0, 8'sd0);

    for (int p = 0; p < PHASES; p++) begin
      unique case (p)
        0: begin
          hi_set = '0;
          lo_set = '0;
        end
        1: begin
          hi_set = '1;
          lo_set = '1;
        end
        2: begin
          hi_set = '1;
          lo_set = '0;
        end
        3: begin
          hi_set = '0;
          lo_set = '1;
        end
        4, 5, 6, 7: begin
          hi_set = random_gains(16'h0400);
          lo_set = random_gains(16'h0400);
        end
        default: begin
          hi_set = random_gains(16'hFFFF);
          lo_set = random_gains(16'hFFFF);
        end
      endcase
      write_gains(hi_set, lo_set);
      repeat (PHASE_ITEMS) random_tick();
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
